FILE: rtl/hpet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpet_pkg
// Shared widths, operation and status codes, and item types of the
// healthy priority entry table.
// ----------------------------------------------------------------------------
package hpet_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 3;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FAIL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SYNC = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  // one request item
  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [KEY_W-1:0]         key;
    logic signed [PRIO_W-1:0] priority_req;
  } item_t;

  // table update request from the input stage
  typedef struct packed {
    logic  fire;
    item_t item;
  } upd_t;

  // one result item
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     best_valid;
    logic [SLOT_W-1:0]        best_slot;
    logic [KEY_W-1:0]         best_key;
    logic signed [PRIO_W-1:0] best_priority;
  } res_t;

endpackage

FILE: rtl/hpet_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpet_if
// Valid/ready channels of the healthy priority entry table: request items
// in, result items out.
// ----------------------------------------------------------------------------
interface hpet_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [63:0]         key;
  logic signed [15:0]  priority_req;

  modport source (output valid, func, key, priority_req, input ready);
  modport sink   (input valid, func, key, priority_req, output ready);
endinterface

interface hpet_out_if;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic                best_valid;
  logic [2:0]          best_slot;
  logic [63:0]         best_key;
  logic signed [15:0]  best_priority;

  modport source (output valid, status, best_valid, best_slot, best_key, best_priority,
                  input ready);
  modport sink   (input valid, status, best_valid, best_slot, best_key, best_priority,
                  output ready);
endinterface

FILE: rtl/hpet_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpet_table
// Entry storage with key match, free slot search and the add, fail and
// sync updates. Gives the status of the item being applied.
// ----------------------------------------------------------------------------
module hpet_table import hpet_pkg::*; #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  upd_t                     upd_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [ENTRIES-1:0]       used_o,
  output logic [ENTRIES-1:0]       healthy_o,
  output logic [KEY_W-1:0]         key_o  [ENTRIES],
  output logic signed [PRIO_W-1:0] prio_o [ENTRIES]
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [ENTRIES-1:0]       used_q;
  logic [ENTRIES-1:0]       healthy_q;
  logic [KEY_W-1:0]         key_q  [ENTRIES];
  logic signed [PRIO_W-1:0] prio_q [ENTRIES];

  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             wr_en;
  logic             wr_fill;
  logic             wr_healthy;
  logic [IDX_W-1:0] wr_idx;

  // lowest used slot with a matching key, lowest free slot
  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (used_q[i] && (key_q[i] == upd_i.item.key)) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // decode the operation into one slot write
  always_comb begin
    wr_en      = 1'b0;
    wr_fill    = 1'b0;
    wr_healthy = 1'b0;
    wr_idx     = hit_idx;
    status_o   = STATUS_OK;
    unique case (upd_i.item.func)
      FUNC_ADD: begin
        wr_fill    = 1'b1;
        wr_healthy = 1'b1;
        if (hit_found) begin
          wr_en = 1'b1;
        end else if (free_found) begin
          wr_en  = 1'b1;
          wr_idx = free_idx;
        end else begin
          status_o = STATUS_FULL;
        end
      end
      FUNC_FAIL, FUNC_SYNC: begin
        wr_healthy = (upd_i.item.func == FUNC_SYNC);
        if (hit_found) begin
          wr_en = 1'b1;
        end else begin
          status_o = STATUS_NOT_FOUND;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // used marks, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (upd_i.fire && wr_en && wr_fill) begin
      used_q[wr_idx] <= 1'b1;
    end
  end

  // entry payload, meaningful only while used
  always_ff @(posedge clk_i) begin
    if (upd_i.fire && wr_en) begin
      healthy_q[wr_idx] <= wr_healthy;
      if (wr_fill) begin
        key_q[wr_idx]  <= upd_i.item.key;
        prio_q[wr_idx] <= upd_i.item.priority_req;
      end
    end
  end

  assign used_o    = used_q;
  assign healthy_o = healthy_q;
  assign key_o     = key_q;
  assign prio_o    = prio_q;

endmodule

FILE: rtl/hpet_best.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpet_best
// Compare tree picking the used, healthy entry of highest priority; the
// lower slot wins on equal priority.
// ----------------------------------------------------------------------------
module hpet_best import hpet_pkg::*; #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic [ENTRIES-1:0]       used_i,
  input  logic [ENTRIES-1:0]       healthy_i,
  input  logic [KEY_W-1:0]         key_i  [ENTRIES],
  input  logic signed [PRIO_W-1:0] prio_i [ENTRIES],
  output logic                     best_valid_o,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] best_idx_o,
  output logic [KEY_W-1:0]         best_key_o,
  output logic signed [PRIO_W-1:0] best_prio_o
);

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LEAVES = 1 << IDX_W;
  localparam int unsigned NODES  = 2 * LEAVES - 1;

  logic                     nd_vld  [NODES];
  logic signed [PRIO_W-1:0] nd_prio [NODES];
  logic [IDX_W-1:0]         nd_idx  [NODES];

  // heap-ordered tree, leaves left to right by slot
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < ENTRIES) begin
        nd_vld[LEAVES-1+i]  = used_i[i] && healthy_i[i];
        nd_prio[LEAVES-1+i] = prio_i[i];
      end else begin
        nd_vld[LEAVES-1+i]  = 1'b0;
        nd_prio[LEAVES-1+i] = '0;
      end
      nd_idx[LEAVES-1+i] = IDX_W'(i);
    end
    for (int n = LEAVES - 2; n >= 0; n--) begin
      if (nd_vld[2*n+2] && (!nd_vld[2*n+1] || (nd_prio[2*n+2] > nd_prio[2*n+1]))) begin
        nd_vld[n]  = 1'b1;
        nd_prio[n] = nd_prio[2*n+2];
        nd_idx[n]  = nd_idx[2*n+2];
      end else begin
        nd_vld[n]  = nd_vld[2*n+1];
        nd_prio[n] = nd_prio[2*n+1];
        nd_idx[n]  = nd_idx[2*n+1];
      end
    end
  end

  // winner fields, zero when no entry qualifies
  always_comb begin
    best_valid_o = nd_vld[0];
    best_idx_o   = '0;
    best_key_o   = '0;
    best_prio_o  = '0;
    if (nd_vld[0]) begin
      best_idx_o  = nd_idx[0];
      best_key_o  = key_i[nd_idx[0]];
      best_prio_o = nd_prio[0];
    end
  end

endmodule

FILE: rtl/healthy_priority_entry_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// healthy_priority_entry_table
// Keyed entry table with signed priorities and health flags, reporting the
// best healthy entry after every item.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries request items (func, key, priority_req); out_o carries one
//   result item per request (status and the best healthy entry after it).
//   Both channels move an item when valid and ready are high at a clock edge.
//   Pipeline: input register, table update, best-entry tree, result register.
//   Items pass the input register and status stage into the result register.
//   Throughput is one item per cycle; the table update of one item lands
//   in the same edge the next item is captured, so items follow back to back.
//   The whole pipeline advances together: when the result register holds an
//   item and out_o.ready is low, in_i.ready drops and all stages hold.
//   Reset clears all used marks and empties the pipeline; key, priority and
//   health storage is written only when a slot is taken or updated.
//   ENTRIES sets the table depth (1 to 64); best_slot carries the low three
//   bits of the slot index.
// ----------------------------------------------------------------------------
module healthy_priority_entry_table import hpet_pkg::*; #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hpet_in_if.sink     in_i,
  hpet_out_if.source  out_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic                     adv;
  logic                     s1_valid_q;
  item_t                    s1_item_q;
  logic                     s2_valid_q;
  logic [STATUS_W-1:0]      s2_status_q;
  logic                     out_valid_q;
  res_t                     out_q;
  res_t                     out_d;
  upd_t                     upd;
  logic [STATUS_W-1:0]      tbl_status;
  logic [ENTRIES-1:0]       tbl_used;
  logic [ENTRIES-1:0]       tbl_healthy;
  logic [KEY_W-1:0]         tbl_key  [ENTRIES];
  logic signed [PRIO_W-1:0] tbl_prio [ENTRIES];
  logic                     best_valid;
  logic [IDX_W-1:0]         best_idx;
  logic [KEY_W-1:0]         best_key;
  logic signed [PRIO_W-1:0] best_prio;

  // pipeline moves when the result register is free or being drained
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_i.valid) begin
      s1_item_q.func         <= in_i.func;
      s1_item_q.key          <= in_i.key;
      s1_item_q.priority_req <= in_i.priority_req;
    end
  end

  // table update for the item in the input register
  assign upd.fire = adv && s1_valid_q;
  assign upd.item = s1_item_q;

  hpet_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (upd),
    .status_o  (tbl_status),
    .used_o    (tbl_used),
    .healthy_o (tbl_healthy),
    .key_o     (tbl_key),
    .prio_o    (tbl_prio)
  );

  // status stage, table now holds this item's effect
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd.fire) begin
      s2_status_q <= tbl_status;
    end
  end

  hpet_best #(
    .ENTRIES (ENTRIES)
  ) u_best (
    .used_i       (tbl_used),
    .healthy_i    (tbl_healthy),
    .key_i        (tbl_key),
    .prio_i       (tbl_prio),
    .best_valid_o (best_valid),
    .best_idx_o   (best_idx),
    .best_key_o   (best_key),
    .best_prio_o  (best_prio)
  );

  // result register
  always_comb begin
    out_d.status        = s2_status_q;
    out_d.best_valid    = best_valid;
    out_d.best_slot     = SLOT_W'(best_idx);
    out_d.best_key      = best_key;
    out_d.best_priority = best_prio;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_q.status;
  assign out_o.best_valid    = out_q.best_valid;
  assign out_o.best_slot     = out_q.best_slot;
  assign out_o.best_key      = out_q.best_key;
  assign out_o.best_priority = out_q.best_priority;

`ifndef NO_ASSERTIONS
  // an item leaving the input register reaches the status stage
  a_s1_to_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q) |=> s2_valid_q)
    else $error("item lost between input and status stage");

  // used marks only ever get set
  a_used_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tbl_used) >= $past($countones(tbl_used)))
    else $error("used mark cleared outside reset");

  // full is only reported when every slot is taken
  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && (s2_status_q == STATUS_FULL)) |-> (&tbl_used))
    else $error("full status with a free slot");

  // the chosen entry is used and healthy
  a_best_qualifies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && best_valid) |-> (tbl_used[best_idx] && tbl_healthy[best_idx]))
    else $error("best entry not used and healthy");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the healthy priority entry table. A scoreboard
// keeps its own copy of the slot table, predicts the status and best
// healthy entry for every accepted request item, and checks each result
// item in order. A short directed sequence walks through the corner cases,
// then random items mostly hit stored keys, with some noise mixed in. Both
// channels idle at random, with bursts of back-to-back traffic.
// ----------------------------------------------------------------------------
module testbench import hpet_pkg::*; ();

  localparam int unsigned TABLE_DEPTH  = 8;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

  // shadow table and in-order result check
  class entry_scoreboard;
    bit                       used [TABLE_DEPTH];
    logic [KEY_W-1:0]         slot_key [TABLE_DEPTH];
    logic signed [PRIO_W-1:0] slot_prio [TABLE_DEPTH];
    bit                       slot_healthy [TABLE_DEPTH];
    res_t                     pending_results [$];
    int unsigned              mismatches;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      mismatches = 0;
    endfunction

    function int find_slot(logic [KEY_W-1:0] key);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (used[i] && slot_key[i] == key) return i;
      end
      return -1;
    endfunction

    // apply one request to the table and queue the result it causes
    function void note_request(item_t req);
      int   hit;
      int   best;
      res_t res;
      res = '0;
      res.status = STATUS_OK;
      hit = find_slot(req.key);
      case (req.func)
        FUNC_ADD: begin
          for (int i = 0; i < TABLE_DEPTH && hit < 0; i++) begin
            if (!used[i]) hit = i;
          end
          if (hit < 0) begin
            res.status = STATUS_FULL;
          end else begin
            used[hit]         = 1'b1;
            slot_key[hit]     = req.key;
            slot_prio[hit]    = req.priority_req;
            slot_healthy[hit] = 1'b1;
          end
        end
        FUNC_FAIL, FUNC_SYNC: begin
          if (hit < 0) res.status = STATUS_NOT_FOUND;
          else slot_healthy[hit] = (req.func == FUNC_SYNC);
        end
        default: ;
      endcase
      // highest priority healthy slot, lowest index on ties
      best = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (used[i] && slot_healthy[i] && (best < 0 || slot_prio[i] > slot_prio[best])) begin
          best = i;
        end
      end
      if (best >= 0) begin
        res.best_valid    = 1'b1;
        res.best_slot     = SLOT_W'(best);
        res.best_key      = slot_key[best];
        res.best_priority = slot_prio[best];
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("result item with none expected: status %0d, best_key %h",
               got.status, got.best_key);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.best_valid !== want.best_valid) begin
        $error("best_valid: expected %0d, actual %0d", want.best_valid, got.best_valid);
        mismatches++;
      end
      if (got.best_slot !== want.best_slot) begin
        $error("best_slot: expected %0d, actual %0d", want.best_slot, got.best_slot);
        mismatches++;
      end
      if (got.best_key !== want.best_key) begin
        $error("best_key: expected %h, actual %h", want.best_key, got.best_key);
        mismatches++;
      end
      if (got.best_priority !== want.best_priority) begin
        $error("best_priority: expected %0d, actual %0d",
               want.best_priority, got.best_priority);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady_flow;

  entry_scoreboard sb = new();

  hpet_in_if  req_if ();
  hpet_out_if res_if ();

  healthy_priority_entry_table #(
    .ENTRIES (TABLE_DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // note accepted requests and check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        sb.note_request(item_t'{func: req_if.func, key: req_if.key,
                                priority_req: req_if.priority_req});
      end
      if (res_if.valid && res_if.ready) begin
        sb.check_result(res_t'{status: res_if.status, best_valid: res_if.best_valid,
                               best_slot: res_if.best_slot, best_key: res_if.best_key,
                               best_priority: res_if.best_priority});
      end
    end
  end

  // result side: random stall before each item
  initial begin
    int unsigned stall;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
    end
  end

  // drive one request item and wait until it is taken
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                              input logic signed [PRIO_W-1:0] prio);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.func         <= func;
    req_if.key          <= key;
    req_if.priority_req <= prio;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // a key that no used slot holds
  function automatic logic [KEY_W-1:0] absent_key();
    logic [KEY_W-1:0] k;
    do k = random_key(); while (sb.find_slot(k) >= 0);
    return k;
  endfunction

  // extremes and small values often, so that ties come up
  function automatic logic signed [PRIO_W-1:0] pick_priority();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      default: return PRIO_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return FUNC_ADD;
      4, 5, 6:    return FUNC_FAIL;
      default:    return FUNC_SYNC;
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned idx;
    req_if.valid        <= 1'b0;
    req_if.func         <= FUNC_ADD;
    req_if.key          <= '0;
    req_if.priority_req <= '0;
    rst_ni = 1'b0;
    steady_flow = ($urandom_range(0, 1) == 0);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: misses and unknown operation
    send_request(FUNC_FAIL, '0, 16'sh7fff);
    send_request(FUNC_SYNC, '1, 16'sh8000);
    send_request(FUNC_UNKNOWN, random_key(), pick_priority());
    // extremes of key and priority
    send_request(FUNC_ADD, '1, 16'sh7fff);
    send_request(FUNC_ADD, '0, 16'sh8000);
    send_request(FUNC_FAIL, '1, pick_priority());
    send_request(FUNC_SYNC, '0, pick_priority());
    // used entries but none healthy
    send_request(FUNC_FAIL, '0, pick_priority());
    send_request(FUNC_SYNC, '1, pick_priority());
    // equal priority: lower slot wins
    send_request(FUNC_ADD, 64'h5555_5555_5555_5555, 16'sh7fff);
    send_request(FUNC_FAIL, '1, pick_priority());
    // update of a stored key heals it with the new priority
    send_request(FUNC_ADD, '1, 16'sd100);
    send_request(FUNC_ADD, 64'haaaa_aaaa_aaaa_aaaa, 16'sh7fff);
    // fill the rest, then a new key finds the table full
    repeat (TABLE_DEPTH - 4) send_request(FUNC_ADD, absent_key(), pick_priority());
    send_request(FUNC_ADD, absent_key(), pick_priority());
    send_request(FUNC_FAIL, absent_key(), pick_priority());
    send_request(FUNC_UNKNOWN, '1, pick_priority());
    send_request(FUNC_SYNC, '0, pick_priority());
    send_request(FUNC_ADD, '0, -16'sd1);

    // random items, mostly on stored keys
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        do idx = $urandom_range(0, TABLE_DEPTH - 1); while (!sb.used[idx]);
        send_request(pick_func(), sb.slot_key[idx], pick_priority());
      end else begin
        send_request(FUNC_W'($urandom_range(0, 3)), random_key(),
                     PRIO_W'($urandom_range(0, 65535)));
      end
    end
    req_if.valid <= 1'b0;

    // drain outstanding results
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
